// ----- hw/rtl/y2b_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// y2b_pkg
// Types and fixed constants for the YUYV pair to BGR converter.
// ----------------------------------------------------------------------------
package y2b_pkg;

    localparam int unsigned PIX_W   = 8;
    localparam int unsigned MAG_W   = 8;   // |chroma - 128| reaches 128
    localparam int unsigned PROD_W  = 21;  // largest product 14075*128
    localparam int unsigned RCP_W   = 22;
    localparam int unsigned QPROD_W = PROD_W + RCP_W;
    localparam int unsigned QUOT_W  = 8;   // largest quotient 227
    localparam int unsigned OFF_W   = 9;   // signed chroma term
    localparam int unsigned SUM_W   = 11;  // signed luma plus term

    localparam logic [PIX_W-1:0] CHAN_MAX    = 8'd255;
    localparam logic [MAG_W-1:0] CHROMA_ZERO = 8'd128;

    // coefficients: red from Cr, green from Cb and Cr, blue from Cb
    localparam logic [PROD_W-1:0] COEF_RED_V = 21'd14075;
    localparam logic [PROD_W-1:0] COEF_GRN_U = 21'd3455;
    localparam logic [PROD_W-1:0] COEF_GRN_V = 21'd7169;
    localparam logic [PROD_W-1:0] COEF_BLU_U = 21'd1779;

    // floor(p / 10000) = (p * ceil(2^35 / 10000)) >> 35 for p < 2^21
    localparam logic [RCP_W-1:0] RCP_10K   = 22'd3435974;
    localparam int unsigned      SHIFT_10K = 35;
    // floor(p / 1000) = (p * ceil(2^31 / 1000)) >> 31 for p < 2^21
    localparam logic [RCP_W-1:0] RCP_1K    = 22'd2147484;
    localparam int unsigned      SHIFT_1K  = 31;

    typedef struct packed {
        logic [PIX_W-1:0] luma_first;
        logic [PIX_W-1:0] chroma_blue;
        logic [PIX_W-1:0] luma_second;
        logic [PIX_W-1:0] chroma_red;
    } t_req;

    typedef struct packed {
        logic [PIX_W-1:0] blue_first;
        logic [PIX_W-1:0] green_first;
        logic [PIX_W-1:0] red_first;
        logic [PIX_W-1:0] blue_second;
        logic [PIX_W-1:0] green_second;
        logic [PIX_W-1:0] red_second;
    } t_rsp;

    // chroma terms shared by both pixels, with the lumas carried alongside
    typedef struct packed {
        logic [PIX_W-1:0]        luma_first;
        logic [PIX_W-1:0]        luma_second;
        logic signed [OFF_W-1:0] blu_off;
        logic signed [OFF_W-1:0] grn_off;
        logic signed [OFF_W-1:0] red_off;
    } t_terms;

endpackage : y2b_pkg
`default_nettype wire

// ----- hw/rtl/y2b_chroma.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// y2b_chroma
// Four-stage chroma path: magnitude, constant product, reciprocal divide,
// signed term. Lumas ride along with the valid bit.
// ----------------------------------------------------------------------------
module y2b_chroma
    import y2b_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_valid,
    input  wire t_req   i_req,
    output logic        o_valid,
    output t_terms      o_terms
);

    // stage 1: sign and magnitude of the offset chroma
    logic             r_v1;
    logic [MAG_W-1:0] r_mag_u, r_mag_v;
    logic             r_neg_u1, r_neg_v1;
    logic [PIX_W-1:0] r_ya1, r_yb1;

    // stage 2: constant products
    logic              r_v2;
    logic [PROD_W-1:0] r_p_rv, r_p_gu, r_p_gv, r_p_bu;
    logic              r_neg_u2, r_neg_v2;
    logic [PIX_W-1:0]  r_ya2, r_yb2;

    // stage 3: quotients
    logic              r_v3;
    logic [QUOT_W-1:0] r_q_rv, r_q_gu, r_q_gv, r_q_bu;
    logic              r_neg_u3, r_neg_v3;
    logic [PIX_W-1:0]  r_ya3, r_yb3;

    // stage 4: signed terms
    logic   r_v4;
    t_terms r_terms;

    logic [QPROD_W-1:0] n_qp_rv, n_qp_gu, n_qp_gv, n_qp_bu;
    logic [OFF_W-1:0]   n_q_rv, n_q_gu, n_q_gv, n_q_bu;

    always_comb begin
        n_qp_rv = QPROD_W'(r_p_rv) * QPROD_W'(RCP_10K);
        n_qp_gu = QPROD_W'(r_p_gu) * QPROD_W'(RCP_10K);
        n_qp_gv = QPROD_W'(r_p_gv) * QPROD_W'(RCP_10K);
        n_qp_bu = QPROD_W'(r_p_bu) * QPROD_W'(RCP_1K);
        n_q_rv  = {1'b0, r_q_rv};
        n_q_gu  = {1'b0, r_q_gu};
        n_q_gv  = {1'b0, r_q_gv};
        n_q_bu  = {1'b0, r_q_bu};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end

        // stage 1
        r_neg_u1 <= ~i_req.chroma_blue[PIX_W-1];
        r_neg_v1 <= ~i_req.chroma_red[PIX_W-1];
        r_mag_u  <= i_req.chroma_blue[PIX_W-1] ? {1'b0, i_req.chroma_blue[PIX_W-2:0]}
                                               : CHROMA_ZERO - i_req.chroma_blue;
        r_mag_v  <= i_req.chroma_red[PIX_W-1] ? {1'b0, i_req.chroma_red[PIX_W-2:0]}
                                              : CHROMA_ZERO - i_req.chroma_red;
        r_ya1    <= i_req.luma_first;
        r_yb1    <= i_req.luma_second;

        // stage 2
        r_p_rv   <= PROD_W'(r_mag_v) * COEF_RED_V;
        r_p_gu   <= PROD_W'(r_mag_u) * COEF_GRN_U;
        r_p_gv   <= PROD_W'(r_mag_v) * COEF_GRN_V;
        r_p_bu   <= PROD_W'(r_mag_u) * COEF_BLU_U;
        r_neg_u2 <= r_neg_u1;
        r_neg_v2 <= r_neg_v1;
        r_ya2    <= r_ya1;
        r_yb2    <= r_yb1;

        // stage 3
        r_q_rv   <= n_qp_rv[SHIFT_10K +: QUOT_W];
        r_q_gu   <= n_qp_gu[SHIFT_10K +: QUOT_W];
        r_q_gv   <= n_qp_gv[SHIFT_10K +: QUOT_W];
        r_q_bu   <= n_qp_bu[SHIFT_1K +: QUOT_W];
        r_neg_u3 <= r_neg_u2;
        r_neg_v3 <= r_neg_v2;
        r_ya3    <= r_ya2;
        r_yb3    <= r_yb2;

        // stage 4: truncation toward zero, sign applied to the magnitude quotient
        r_terms.luma_first  <= r_ya3;
        r_terms.luma_second <= r_yb3;
        r_terms.blu_off     <= r_neg_u3 ? -$signed(n_q_bu) : $signed(n_q_bu);
        r_terms.red_off     <= r_neg_v3 ? -$signed(n_q_rv) : $signed(n_q_rv);
        r_terms.grn_off     <= (r_neg_u3 ? $signed(n_q_gu) : -$signed(n_q_gu))
                             + (r_neg_v3 ? $signed(n_q_gv) : -$signed(n_q_gv));
    end

    assign o_valid = r_v4;
    assign o_terms = r_terms;

endmodule : y2b_chroma
`default_nettype wire

// ----- hw/rtl/y2b_mix.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// y2b_mix
// Adds the shared chroma terms to both lumas and saturates each channel.
// ----------------------------------------------------------------------------
module y2b_mix
    import y2b_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_valid,
    input  wire t_terms i_terms,
    output logic        o_valid,
    output t_rsp        o_rsp
);

    logic r_valid;
    t_rsp r_rsp;
    t_rsp n_rsp;

    function automatic logic [PIX_W-1:0] sat_add(input logic [PIX_W-1:0] y,
                                                 input logic signed [OFF_W-1:0] off);
        logic signed [SUM_W-1:0] sum;
        logic [PIX_W-1:0]        res;
        sum = $signed({{(SUM_W-PIX_W){1'b0}}, y})
            + $signed({{(SUM_W-OFF_W){off[OFF_W-1]}}, off});
        if (sum[SUM_W-1]) begin
            res = '0;
        end else if (sum[SUM_W-2:PIX_W] != '0) begin
            res = CHAN_MAX;
        end else begin
            res = sum[PIX_W-1:0];
        end
        return res;
    endfunction

    always_comb begin
        n_rsp.blue_first   = sat_add(i_terms.luma_first,  i_terms.blu_off);
        n_rsp.green_first  = sat_add(i_terms.luma_first,  i_terms.grn_off);
        n_rsp.red_first    = sat_add(i_terms.luma_first,  i_terms.red_off);
        n_rsp.blue_second  = sat_add(i_terms.luma_second, i_terms.blu_off);
        n_rsp.green_second = sat_add(i_terms.luma_second, i_terms.grn_off);
        n_rsp.red_second   = sat_add(i_terms.luma_second, i_terms.red_off);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_rsp <= n_rsp;
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

endmodule : y2b_mix
`default_nettype wire

// ----- hw/rtl/yuyv_pair_to_bgr_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// yuyv_pair_to_bgr_core
// YUYV 4:2:2 word to two saturated BGR888 pixels, five-stage pipeline.
//
//   channel   ports                       handshake
//   request   i_req (t_req)               i_start while o_busy low
//   result    o_rsp (t_rsp)               o_valid, one cycle, no back-pressure
//
// A request is taken every cycle while o_busy is low.
// The chroma path (magnitude, product, reciprocal divide, signed term) takes
// four stages, the luma add and saturation the fifth.
// o_busy is high only while in reset and for the first cycle after;
// reset drops every request in flight. Results are never held off.
// ----------------------------------------------------------------------------
module yuyv_pair_to_bgr_core
    import y2b_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire t_req i_req,
    output logic      o_busy,
    output logic      o_valid,
    output t_rsp      o_rsp
);

    logic   r_busy;
    logic   w_accept;
    logic   w_terms_valid;
    t_terms w_terms;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign o_busy   = r_busy;
    assign w_accept = i_start & ~r_busy;

    y2b_chroma u_chroma (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_req   (i_req),
        .o_valid (w_terms_valid),
        .o_terms (w_terms)
    );

    y2b_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_terms_valid),
        .i_terms (w_terms),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

    // every accepted request gives a result at the pipeline output
    a_req_to_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##5 o_valid)
        else $error("request lost in pipeline");

    // no result without a matching earlier request
    a_rsp_from_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_accept, 5))
        else $error("result without request");

    // neutral chroma passes luma through unchanged to first red and second blue
    a_neutral: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_req.chroma_blue == CHROMA_ZERO && i_req.chroma_red == CHROMA_ZERO)
        |-> ##5 (o_rsp.red_first == $past(i_req.luma_first, 5)
              && o_rsp.blue_second == $past(i_req.luma_second, 5)))
        else $error("neutral chroma altered luma");

    // reset always leaves the core busy for the next cycle
    a_busy_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_busy)
        else $error("busy not set by reset");

endmodule : yuyv_pair_to_bgr_core
`default_nettype wire

// ----- tb/sv/yuyv_pair_to_bgr_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuyv_pair_to_bgr_core_tb
// Self-checking bench for the YUYV pair to BGR converter. Requests go in as
// corner words, one unbroken stream and random bursts with random gaps. Each
// result is matched in order against a software conversion of the request.
// ----------------------------------------------------------------------------
module yuyv_pair_to_bgr_core_tb;
    import y2b_pkg::*;

    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 11;
    localparam int DRAIN_CYCLES  = 12;   // pipeline is five deep
    localparam int REPORT_LIMIT  = 10;
    localparam int STREAM_PAIRS  = 300;
    localparam int BURST_PAIRS   = 1200;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_start = 1'b0;
    t_req i_req   = '0;
    logic o_busy;
    logic o_valid;
    t_rsp o_rsp;

    t_rsp expected_bgr_q[$];
    int   mismatch_count = 0;

    yuyv_pair_to_bgr_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_req   (i_req),
        .o_busy  (o_busy),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

    always begin
        #(CLK_HALF) i_clk = 1'b1;
        #(CLK_HALF) i_clk = 1'b0;
    end

    function automatic logic [PIX_W-1:0] clamp_chan(int sum);
        if (sum < 0) begin
            return '0;
        end
        if (sum > 255) begin
            return 8'd255;
        end
        return sum[PIX_W-1:0];
    endfunction

    // each chroma term truncates toward zero on its own, shared by both pixels
    function automatic t_rsp convert_yuyv(t_req pair);
        t_rsp px;
        int   cb_off;
        int   cr_off;
        int   red_term;
        int   grn_term;
        int   blu_term;
        cb_off   = int'(pair.chroma_blue) - 128;
        cr_off   = int'(pair.chroma_red) - 128;
        red_term = (14075 * cr_off) / 10000;
        grn_term = -((3455 * cb_off) / 10000) - ((7169 * cr_off) / 10000);
        blu_term = (1779 * cb_off) / 1000;
        px.blue_first   = clamp_chan(int'(pair.luma_first) + blu_term);
        px.green_first  = clamp_chan(int'(pair.luma_first) + grn_term);
        px.red_first    = clamp_chan(int'(pair.luma_first) + red_term);
        px.blue_second  = clamp_chan(int'(pair.luma_second) + blu_term);
        px.green_second = clamp_chan(int'(pair.luma_second) + grn_term);
        px.red_second   = clamp_chan(int'(pair.luma_second) + red_term);
        return px;
    endfunction

    // mostly uniform, with a fair share of values at the rails and around zero chroma
    function automatic logic [PIX_W-1:0] pick_sample();
        logic [PIX_W-1:0] val;
        case ($urandom_range(0, 11))
            0: val = 8'd0;
            1: val = 8'd255;
            2: val = 8'd127 + 8'($urandom_range(0, 2));
            3: val = 8'($urandom_range(0, 3));
            default: val = 8'($urandom_range(0, 255));
        endcase
        return val;
    endfunction

    function automatic t_req random_pair();
        t_req pair;
        pair.luma_first  = pick_sample();
        pair.chroma_blue = pick_sample();
        pair.luma_second = pick_sample();
        pair.chroma_red  = pick_sample();
        return pair;
    endfunction

    // holds the request until a clock edge sees start with busy low
    task automatic issue_pair(t_req pair);
        i_start <= 1'b1;
        i_req   <= pair;
        do begin
            @(posedge i_clk);
        end while (o_busy !== 1'b0);
        expected_bgr_q.push_back(convert_yuyv(pair));
    endtask

    task automatic idle_cycles(int n);
        i_start <= 1'b0;
        repeat (n) begin
            i_req <= random_pair();
            @(posedge i_clk);
        end
    endtask

    task automatic test_corner_words();
        logic [PIX_W-1:0] chroma_pts[3];
        t_req             pair;
        chroma_pts = '{8'd0, 8'd128, 8'd255};
        // both luma orders against every mix of chroma rails and neutral
        for (int swap = 0; swap < 2; swap++) begin
            for (int cb = 0; cb < 3; cb++) begin
                for (int cr = 0; cr < 3; cr++) begin
                    pair.luma_first  = swap ? 8'd255 : 8'd0;
                    pair.luma_second = swap ? 8'd0 : 8'd255;
                    pair.chroma_blue = chroma_pts[cb];
                    pair.chroma_red  = chroma_pts[cr];
                    issue_pair(pair);
                end
            end
        end
        // neutral gray, then chroma one step off zero where terms truncate
        issue_pair('{8'd128, 8'd128, 8'd128, 8'd128});
        issue_pair('{8'd16, 8'd129, 8'd235, 8'd127});
        issue_pair('{8'd1, 8'd127, 8'd254, 8'd129});
        idle_cycles(3);
    endtask

    task automatic test_unbroken_stream(int n_pairs);
        for (int k = 0; k < n_pairs; k++) begin
            issue_pair(random_pair());
        end
        idle_cycles(2);
    endtask

    task automatic test_random_bursts(int n_pairs);
        int sent;
        int burst;
        sent = 0;
        while (sent < n_pairs) begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst && sent < n_pairs; k++) begin
                issue_pair(random_pair());
                sent++;
            end
            // gaps up to past the pipeline depth land on every stage
            idle_cycles($urandom_range(1, 8));
        end
    endtask

    always @(posedge i_clk) begin : check_bgr
        t_rsp want;
        if (o_valid === 1'b1) begin
            if (expected_bgr_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT) begin
                    $display("%0t: result with no request pending, got %h", $time, o_rsp);
                end
            end else begin
                want = expected_bgr_q.pop_front();
                if (o_rsp.blue_first !== want.blue_first
                        || o_rsp.green_first !== want.green_first
                        || o_rsp.red_first !== want.red_first
                        || o_rsp.blue_second !== want.blue_second
                        || o_rsp.green_second !== want.green_second
                        || o_rsp.red_second !== want.red_second) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("%0t: bgr mismatch exp %0d %0d %0d | %0d %0d %0d",
                            $time, want.blue_first, want.green_first, want.red_first,
                            want.blue_second, want.green_second, want.red_second);
                        $display("%0t:              got %0d %0d %0d | %0d %0d %0d",
                            $time, o_rsp.blue_first, o_rsp.green_first, o_rsp.red_first,
                            o_rsp.blue_second, o_rsp.green_second, o_rsp.red_second);
                    end
                end
            end
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_corner_words();
        test_unbroken_stream(STREAM_PAIRS);
        test_random_bursts(BURST_PAIRS);

        while (expected_bgr_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && expected_bgr_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #(2_000_000);
        $display("CHECK FAILED");
        $finish;
    end

endmodule : yuyv_pair_to_bgr_core_tb

// ----- files.f -----
hw/rtl/y2b_pkg.sv
hw/rtl/y2b_chroma.sv
hw/rtl/y2b_mix.sv
hw/rtl/yuyv_pair_to_bgr_core.sv
tb/sv/yuyv_pair_to_bgr_core_tb.sv
